// File: design/assert_macros.svh
// assertion macros used by plbb_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/plbb_pkg.sv
// shared types and constants of the per-label bounding box core
package plbb_pkg;

	localparam int LABEL_W         = 6;
	localparam int COORD_W         = 16;
	localparam int NUM_LABELS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic {
		KIND_POINT,
		KIND_FLUSH
	} item_kind_t;

	typedef struct packed {
		item_kind_t                 kind;
		logic [LABEL_W-1:0]         label;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] lx;
		logic signed [COORD_W-1:0] ly;
		logic signed [COORD_W-1:0] hx;
		logic signed [COORD_W-1:0] hy;
	} box_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN,
		ST_LAST
	} walk_state_t;

	// queue side flags seen by the front and the back
	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

// File: design/plbb_queue.sv
// short item queue between front and back
module plbb_queue import plbb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = slot_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.valid = (count_q != '0);

endmodule

// File: design/plbb_front.sv
// front end: accepts items, classifies them and drops points off the table
module plbb_front import plbb_pkg::*; #(
	parameter int NUM_LABELS = NUM_LABELS_DEF
) (
	input  logic                       start,
	input  logic                       cmd,
	input  logic [LABEL_W-1:0]         label,
	input  logic signed [COORD_W-1:0]  point_x,
	input  logic signed [COORD_W-1:0]  point_y,
	input  q_status_t                  status,
	output logic                       busy,
	output logic                       push,
	output item_t                      push_item
);

	logic accept;
	logic in_range;

	assign busy     = status.full;
	assign accept   = start && !status.full;
	assign in_range = ((LABEL_W + 1)'(label) < (LABEL_W + 1)'(NUM_LABELS));

	// a point whose label is beyond the table changes nothing
	assign push = accept && (cmd || in_range);

	always_comb begin
		push_item.kind  = cmd ? KIND_FLUSH : KIND_POINT;
		push_item.label = label;
		push_item.x     = point_x;
		push_item.y     = point_y;
	end

endmodule

// File: design/plbb_back.sv
// back end: box table update with forwarding, and the flush walk
`include "assert_macros.svh"

module plbb_back import plbb_pkg::*; #(
	parameter int NUM_LABELS = NUM_LABELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  q_status_t                  status,
	input  item_t                      head,
	output logic                       pop,
	output logic                       strobe,
	output logic [LABEL_W-1:0]         box_label,
	output logic signed [COORD_W-1:0]  low_x,
	output logic signed [COORD_W-1:0]  low_y,
	output logic signed [COORD_W-1:0]  high_x,
	output logic signed [COORD_W-1:0]  high_y,
	output logic                       empty_res,
	output logic                       last
);

	localparam int IDX_W = $clog2(NUM_LABELS);

	walk_state_t state_q, state_d;

	box_t                       box_mem_q [NUM_LABELS];
	box_t                       rd_box_q;
	logic [IDX_W-1:0]           rd_addr;

	logic [NUM_LABELS-1:0]      occ_q;
	logic [IDX_W-1:0]           idx_q;

	logic                       pop_point, pop_flush;
	logic [IDX_W-1:0]           head_idx;

	logic                       pt_v_s1;
	logic [IDX_W-1:0]           pt_lab_s1;
	logic signed [COORD_W-1:0]  pt_x_s1, pt_y_s1;
	logic                       fwd_q;
	box_t                       fwd_box_q;
	box_t                       old_box, new_box;

	logic                       wv_s1, wocc_s1;
	logic [IDX_W-1:0]           wlab_s1;
	logic                       take;
	logic                       pend_v_q;
	logic [IDX_W-1:0]           pend_lab_q;
	box_t                       pend_box_q;

	logic                       emit, emit_last, emit_empty;
	logic [LABEL_W-1:0]         emit_lab;
	box_t                       emit_box;

	logic                       strobe_q, last_q, empty_q;
	logic [LABEL_W-1:0]         lab_q;
	box_t                       out_box_q;

	assign head_idx  = head.label[IDX_W-1:0];
	assign pop       = status.valid && (state_q == ST_IDLE);
	assign pop_point = pop && (head.kind == KIND_POINT);
	assign pop_flush = pop && (head.kind == KIND_FLUSH);
	assign rd_addr   = (state_q == ST_WALK) ? idx_q : head_idx;

	// box memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (pt_v_s1) begin
			box_mem_q[pt_lab_s1] <= new_box;
		end
		rd_box_q <= box_mem_q[rd_addr];
	end

	// merge point into stored or forwarded box
	always_comb begin
		old_box = fwd_q ? fwd_box_q : rd_box_q;
		if (occ_q[pt_lab_s1]) begin
			new_box.lx = (pt_x_s1 < old_box.lx) ? pt_x_s1 : old_box.lx;
			new_box.hx = (pt_x_s1 > old_box.hx) ? pt_x_s1 : old_box.hx;
			new_box.ly = (pt_y_s1 < old_box.ly) ? pt_y_s1 : old_box.ly;
			new_box.hy = (pt_y_s1 > old_box.hy) ? pt_y_s1 : old_box.hy;
		end else begin
			new_box.lx = pt_x_s1;
			new_box.hx = pt_x_s1;
			new_box.ly = pt_y_s1;
			new_box.hy = pt_y_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_lab_s1 <= head_idx;
		pt_x_s1   <= head.x;
		pt_y_s1   <= head.y;
		fwd_box_q <= new_box;
		wocc_s1   <= occ_q[idx_q];
		wlab_s1   <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pt_v_s1 <= 1'b0;
			fwd_q   <= 1'b0;
			wv_s1   <= 1'b0;
			idx_q   <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			pt_v_s1 <= pop_point;
			fwd_q   <= pt_v_s1 && pop_point && (head_idx == pt_lab_s1);
			wv_s1   <= (state_q == ST_WALK);
			if (pop_flush) begin
				idx_q <= '0;
			end else if (state_q == ST_WALK) begin
				idx_q <= idx_q + 1'b1;
			end
			if (pt_v_s1) begin
				occ_q[pt_lab_s1] <= 1'b1;
			end
			if (state_q == ST_WALK) begin
				occ_q[idx_q] <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_flush) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (idx_q == IDX_W'(NUM_LABELS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_LAST;
			ST_LAST: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// one box is held back so the final one can carry last
	assign take = wv_s1 && wocc_s1;

	always_comb begin
		emit       = 1'b0;
		emit_last  = 1'b0;
		emit_empty = 1'b0;
		emit_lab   = LABEL_W'(pend_lab_q);
		emit_box   = pend_box_q;
		if (state_q == ST_LAST) begin
			emit      = 1'b1;
			emit_last = 1'b1;
			if (!pend_v_q) begin
				emit_empty = 1'b1;
				emit_lab   = '0;
				emit_box   = '0;
			end
		end else if (take && pend_v_q) begin
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_lab_q <= wlab_s1;
			pend_box_q <= rd_box_q;
		end
		if (emit) begin
			lab_q     <= emit_lab;
			out_box_q <= emit_box;
			last_q    <= emit_last;
			empty_q   <= emit_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (take) begin
				pend_v_q <= 1'b1;
			end else if (state_q == ST_LAST) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	assign strobe    = strobe_q;
	assign box_label = lab_q;
	assign low_x     = out_box_q.lx;
	assign low_y     = out_box_q.ly;
	assign high_x    = out_box_q.hx;
	assign high_y    = out_box_q.hy;
	assign empty_res = empty_q;
	assign last      = last_q;

	`ASSERT_RST(a_strobe_from_walk, clk, arst_n, strobe_q |-> $past(state_q == ST_WALK || state_q == ST_FIN || state_q == ST_LAST), "result outside a flush")
	`ASSERT_RST(a_last_ends_flush, clk, arst_n, (strobe_q && last_q) |-> (state_q == ST_IDLE), "last result while flush still running")
	`ASSERT_RST(a_table_clear, clk, arst_n, (state_q == ST_LAST) |-> (occ_q == '0), "labels still occupied after walk")
	`ASSERT_RST(a_point_only_idle, clk, arst_n, pt_v_s1 |-> (state_q == ST_IDLE), "point update during walk")
	`ASSERT_ALWAYS(a_empty_is_last, clk, (strobe_q && empty_q) |-> last_q, "empty result not marked last")

endmodule

// File: design/per_label_bounding_box_core.sv
// top level of the per-label bounding box core
//
// keeps one axis-aligned box per label; items enter on start when busy is low and go into a
// short queue; the back end drains the queue independently; a point item holds the back end
// only for its pop (box memory read, then merge and write the next cycle, with same-label
// forwarding so points stream at one per cycle while no flush holds the back end); a flush
// walks the whole table, one label per cycle, and holds the back end through its own pop,
// the walk over every label and the ST_FIN and ST_LAST states, during which further items fill the queue;
// busy is high only while the queue is full; results appear one per strobe cycle in
// ascending label order, the final one with last, or a single result with empty_res when
// no label was occupied; each result but the final one is released when the registered read
// of the next occupied label is taken, the final one in ST_LAST, and each passes through
// the output registers before its strobe; the receiver must take every
// strobe, since the core cannot be stalled on the result side
module per_label_bounding_box_core import plbb_pkg::*; #(
	parameter int NUM_LABELS  = NUM_LABELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [LABEL_W-1:0]         label,
	input  logic signed [COORD_W-1:0]  point_x,
	input  logic signed [COORD_W-1:0]  point_y,
	output logic                       strobe,
	output logic [LABEL_W-1:0]         box_label,
	output logic signed [COORD_W-1:0]  low_x,
	output logic signed [COORD_W-1:0]  low_y,
	output logic signed [COORD_W-1:0]  high_x,
	output logic signed [COORD_W-1:0]  high_y,
	output logic                       empty_res,
	output logic                       last
);

	// queue link
	logic      push;
	item_t     push_item;
	logic      pop;
	item_t     head;
	q_status_t status;

	// classify and push accepted items
	plbb_front #(
		.NUM_LABELS (NUM_LABELS)
	) u_front (
		.start     (start),
		.cmd       (cmd),
		.label     (label),
		.point_x   (point_x),
		.point_y   (point_y),
		.status    (status),
		.busy      (busy),
		.push      (push),
		.push_item (push_item)
	);

	plbb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	// table update and flush walk
	plbb_back #(
		.NUM_LABELS (NUM_LABELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.head      (head),
		.pop       (pop),
		.strobe    (strobe),
		.box_label (box_label),
		.low_x     (low_x),
		.low_y     (low_y),
		.high_x    (high_x),
		.high_y    (high_y),
		.empty_res (empty_res),
		.last      (last)
	);

endmodule
